FILE: design/bbc_pkg.sv
// bbc_pkg: shared constants, codes and types for the bracket balance checker
// no dependencies; used by bbc_stack_mem, bbc_ctrl and bracket_balance_checker

package bbc_pkg;

    // stack geometry
    localparam int STACK_DEPTH   = 32;
    localparam int BRACKET_TYPES = 4;
    localparam int PTR_W         = $clog2(STACK_DEPTH);
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int TYPE_W   = 2;
    localparam int LINE_W   = 16;
    localparam int COL_W    = 12;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    // input tuser layout, lowest field first
    localparam int KIND_LSB     = 0;
    localparam int TYPE_LSB     = KIND_LSB + KIND_W;
    localparam int IN_TUSER_W   = TYPE_LSB + TYPE_W;

    // input tdata layout, lowest field first
    localparam int LINE_LSB     = 0;
    localparam int COL_LSB      = LINE_LSB + LINE_W;
    localparam int IN_FIELDS_W  = COL_LSB + COL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // output tdata layout, lowest field first; status travels alone in tuser
    localparam int OUT_LINE_LSB   = 0;
    localparam int OUT_COL_LSB    = OUT_LINE_LSB + LINE_W;
    localparam int OUT_COUNT_LSB  = OUT_COL_LSB + COL_W;
    localparam int OUT_FAILED_LSB = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_FIELDS_W   = OUT_FAILED_LSB + 1;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W    = STATUS_W;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_OPENER = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_UNCLOSED  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_REPORT
    } ctrl_state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] btype;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } stack_entry_t;

    typedef struct packed {
        logic               wr_en;
        logic [PTR_W-1:0]   wr_addr;
        stack_entry_t       wr_data;
        logic               rd_en;
        logic [PTR_W-1:0]   rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] btype;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic              last;
    } token_t;

    typedef struct packed {
        status_t            status;
        logic [LINE_W-1:0]  partner_line;
        logic [COL_W-1:0]   partner_column;
        logic [COUNT_W-1:0] open_count;
        logic               list_failed;
        logic               last;
    } result_t;

    function automatic logic type_known(logic [TYPE_W-1:0] t);
        return int'(t) < BRACKET_TYPES;
    endfunction

endpackage

FILE: design/bracket_balance_checker.sv
// bracket_balance_checker: top level, stream ports, result register and checks
// depends on bbc_pkg, bbc_stack_mem and bbc_ctrl
//
//   channel  | direction | handshake          | contents
//   ---------+-----------+--------------------+------------------------------------------
//   s_       | in        | s_tvalid/s_tready  | one token a transaction, s_tlast = last token
//   m_       | out       | m_tvalid/m_tready  | one result a transaction, m_tlast = last result
//
// a token is handled in order: the accept cycle issues the read of the stack top, then
// CS_EXEC, once out_free is high, resolves the token, writes a pushed opener and loads
// the result register. the last token of an error-free list with brackets still open is
// followed by one memory read per unclosed opener, bottom first.
// the result register frees the core from the output side; a stall on m_tready holds
// the core only when a new result is ready to load.
// reset clears the stack pointer, the error latch and the sequencer; the stack
// memory is not cleared since only entries below the pointer are used.

module bracket_balance_checker
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // token_line, token_column
    input  logic [bbc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // token_kind, bracket_type
    input  logic [bbc_pkg::IN_TUSER_W-1:0]    s_tuser,
    input  logic                              s_tlast,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // partner_line, partner_column, open_count, list_failed
    output logic [bbc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status
    output logic [bbc_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                              m_tlast
);

    bbc_pkg::token_t        tok;
    bbc_pkg::result_t       res;
    bbc_pkg::result_t       out_res_reg;
    bbc_pkg::mem_req_t      mem_req;
    bbc_pkg::stack_entry_t  rd_data;
    logic                   res_valid;
    logic                   out_valid_reg;
    logic                   out_free;

    // unpack the token transaction
    assign tok.kind  = s_tuser[bbc_pkg::KIND_LSB +: bbc_pkg::KIND_W];
    assign tok.btype = s_tuser[bbc_pkg::TYPE_LSB +: bbc_pkg::TYPE_W];
    assign tok.line  = s_tdata[bbc_pkg::LINE_LSB +: bbc_pkg::LINE_W];
    assign tok.col   = s_tdata[bbc_pkg::COL_LSB +: bbc_pkg::COL_W];
    assign tok.last  = s_tlast;

    // result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    bbc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (s_tvalid),
        .tok_ready (s_tready),
        .tok       (tok),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    bbc_stack_mem u_stack_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.last;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = bbc_pkg::OUT_TDATA_W'({out_res_reg.list_failed,
                                             out_res_reg.open_count,
                                             out_res_reg.partner_column,
                                             out_res_reg.partner_line});

    // the sequencer only offers a result when the register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result offered while result register is full");

    // one token in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("token accepted while previous token still in work");

    // unclosed reports only come from an error-free list
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.status == bbc_pkg::ST_UNCLOSED))
            |-> !out_res_reg.list_failed)
        else $error("unclosed report in a failed list");

    // the open count never exceeds the stack depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (int'(out_res_reg.open_count) <= bbc_pkg::STACK_DEPTH))
        else $error("open count beyond stack depth");

endmodule

FILE: design/bbc_stack_mem.sv
// bbc_stack_mem: opener stack storage, one write and one read port, registered read
// depends on bbc_pkg

module bbc_stack_mem
(
    input  logic                  clk,
    input  bbc_pkg::mem_req_t     req,
    output bbc_pkg::stack_entry_t rd_data
);

    bbc_pkg::stack_entry_t mem [bbc_pkg::STACK_DEPTH];
    bbc_pkg::stack_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // write-first: a read of the entry written in the same cycle sees the new data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            if (req.wr_en && (req.wr_addr == req.rd_addr))
            begin
                rd_data_reg <= req.wr_data;
            end
            else
            begin
                rd_data_reg <= mem[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bbc_ctrl.sv
// bbc_ctrl: token sequencer, stack pointer, error latch and unclosed report walk
// depends on bbc_pkg; drives the requests of bbc_stack_mem

module bbc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_valid,
    output logic                  tok_ready,
    input  bbc_pkg::token_t       tok,
    input  logic                  out_free,
    output logic                  res_valid,
    output bbc_pkg::result_t      res,
    output bbc_pkg::mem_req_t     mem_req,
    input  bbc_pkg::stack_entry_t rd_data
);

    bbc_pkg::ctrl_state_t          state_reg, state_next;
    logic [bbc_pkg::CNT_W-1:0]     top_reg, top_next;
    logic                          err_reg, err_next;
    logic [bbc_pkg::PTR_W-1:0]     idx_reg, idx_next;
    bbc_pkg::token_t               tok_reg;
    logic [bbc_pkg::KIND_W-1:0]    kind_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbc_pkg::CS_IDLE;
            top_reg   <= '0;
            err_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            err_reg   <= err_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid && tok_ready)
        begin
            tok_reg <= tok;
        end
    end

    // unknown bracket types count as plain tokens
    assign kind_eff = bbc_pkg::type_known(tok_reg.btype) ? tok_reg.kind : bbc_pkg::KIND_OTHER;

    always_comb
    begin
        bbc_pkg::status_t                 status_v;
        logic [bbc_pkg::LINE_W-1:0]       pline_v;
        logic [bbc_pkg::COL_W-1:0]        pcol_v;
        logic [bbc_pkg::CNT_W-1:0]        top_v;
        logic                             err_v;

        status_v   = bbc_pkg::ST_OK;
        pline_v    = '0;
        pcol_v     = '0;
        top_v      = top_reg;
        err_v      = err_reg;
        state_next = state_reg;
        top_next   = top_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        tok_ready  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        mem_req    = '0;

        unique case (state_reg)
            bbc_pkg::CS_IDLE:
            begin
                tok_ready = 1'b1;
                if (tok_valid)
                begin
                    // fetch the top entry for a possible closer
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = bbc_pkg::PTR_W'(top_reg - bbc_pkg::CNT_W'(1));
                    state_next      = bbc_pkg::CS_EXEC;
                end
            end

            bbc_pkg::CS_EXEC:
            begin
                if (out_free)
                begin
                    if (err_reg)
                    begin
                        status_v = bbc_pkg::ST_IGNORED;
                    end
                    else if (kind_eff == bbc_pkg::KIND_OPEN)
                    begin
                        if (top_reg == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH))
                        begin
                            status_v = bbc_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            mem_req.wr_en         = 1'b1;
                            mem_req.wr_addr       = bbc_pkg::PTR_W'(top_reg);
                            mem_req.wr_data.btype = tok_reg.btype;
                            mem_req.wr_data.line  = tok_reg.line;
                            mem_req.wr_data.col   = tok_reg.col;
                            top_v                 = top_reg + bbc_pkg::CNT_W'(1);
                        end
                    end
                    else if (kind_eff == bbc_pkg::KIND_CLOSE)
                    begin
                        if (top_reg == '0)
                        begin
                            status_v = bbc_pkg::ST_NO_OPENER;
                            err_v    = 1'b1;
                        end
                        else if (rd_data.btype != tok_reg.btype)
                        begin
                            status_v = bbc_pkg::ST_MISMATCH;
                            pline_v  = rd_data.line;
                            pcol_v   = rd_data.col;
                            err_v    = 1'b1;
                        end
                        else
                        begin
                            top_v = top_reg - bbc_pkg::CNT_W'(1);
                        end
                    end

                    res_valid          = 1'b1;
                    res.status         = status_v;
                    res.partner_line   = pline_v;
                    res.partner_column = pcol_v;
                    res.open_count     = bbc_pkg::COUNT_W'(top_v);
                    res.list_failed    = err_v;

                    if (!tok_reg.last)
                    begin
                        res.last   = 1'b0;
                        top_next   = top_v;
                        err_next   = err_v;
                        state_next = bbc_pkg::CS_IDLE;
                    end
                    else if (err_v || (top_v == '0))
                    begin
                        res.last   = 1'b1;
                        top_next   = '0;
                        err_next   = 1'b0;
                        state_next = bbc_pkg::CS_IDLE;
                    end
                    else
                    begin
                        // walk the stack from the bottom
                        res.last        = 1'b0;
                        top_next        = top_v;
                        err_next        = 1'b0;
                        idx_next        = '0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_next      = bbc_pkg::CS_REPORT;
                    end
                end
            end

            bbc_pkg::CS_REPORT:
            begin
                if (out_free)
                begin
                    res_valid          = 1'b1;
                    res.status         = bbc_pkg::ST_UNCLOSED;
                    res.partner_line   = rd_data.line;
                    res.partner_column = rd_data.col;
                    res.open_count     = bbc_pkg::COUNT_W'(top_reg);
                    res.list_failed    = 1'b0;
                    if ((bbc_pkg::CNT_W'(idx_reg) + bbc_pkg::CNT_W'(1)) == top_reg)
                    begin
                        res.last   = 1'b1;
                        top_next   = '0;
                        state_next = bbc_pkg::CS_IDLE;
                    end
                    else
                    begin
                        res.last        = 1'b0;
                        idx_next        = idx_reg + bbc_pkg::PTR_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg + bbc_pkg::PTR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = bbc_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

FILE: test/bracket_balance_checker_tb.sv
// bracket_balance_checker_tb: self-checking bench for the bracket balance checker
// depends on bbc_pkg and the bracket_balance_checker design; token lists are driven
// through the s_ stream, every m_ result is checked against an in-bench stack model

module bracket_balance_checker_tb;

    // unused token kind, must behave like an ordinary token
    localparam logic [bbc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    // bracket pairs
    localparam logic [bbc_pkg::TYPE_W-1:0] BR_ROUND  = 2'd0;
    localparam logic [bbc_pkg::TYPE_W-1:0] BR_SQUARE = 2'd1;
    localparam logic [bbc_pkg::TYPE_W-1:0] BR_CURLY  = 2'd2;
    localparam logic [bbc_pkg::TYPE_W-1:0] BR_ANGLE  = 2'd3;

    localparam int RANDOM_TOKENS = 256;   // the directed lists add 22 tokens more
    localparam int HOLD_AFTER    = 150;   // tokens taken before the long receiver hold
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;    // quiet tail once all results are in
    localparam int IDLE_LIMIT    = 3000;  // cycles without any transaction

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [bbc_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic [bbc_pkg::IN_TUSER_W-1:0]     s_tuser = '0;
    logic                               s_tlast = 1'b0;

    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [bbc_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic [bbc_pkg::OUT_TUSER_W-1:0]    m_tuser;
    logic                               m_tlast;

    // tokens waiting for the driver, results the stack model says must come back
    bbc_pkg::token_t  token_queue[$];
    bbc_pkg::result_t due_results[$];

    // stack model state
    logic [bbc_pkg::TYPE_W-1:0] open_type [bbc_pkg::STACK_DEPTH];
    logic [bbc_pkg::LINE_W-1:0] open_line [bbc_pkg::STACK_DEPTH];
    logic [bbc_pkg::COL_W-1:0]  open_col  [bbc_pkg::STACK_DEPTH];
    int                         open_depth = 0;
    logic                       list_broken = 1'b0;

    int     error_count = 0;
    int     tokens_taken = 0;
    int     idle_cycles = 0;

    // driver and receiver pacing
    bbc_pkg::token_t cur_token;
    int     gap_left = 0;
    bit     tx_steady = 1'b0;
    int     stall_left = 0;
    int     hold_left = 0;
    bit     held_off = 1'b0;
    bit     rx_steady = 1'b0;

    bracket_balance_checker u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // stack model
    // ------------------------------------------------------------------

    function automatic void add_result(bbc_pkg::status_t st,
                                       logic [bbc_pkg::LINE_W-1:0] pl,
                                       logic [bbc_pkg::COL_W-1:0] pc, int cnt,
                                       logic failed, logic fin);
        bbc_pkg::result_t r;
        r.status         = st;
        r.partner_line   = pl;
        r.partner_column = pc;
        r.open_count     = bbc_pkg::COUNT_W'(cnt);
        r.list_failed    = failed;
        r.last           = fin;
        due_results = {due_results, r};
    endfunction

    function automatic void queue_token(bbc_pkg::token_t tk);
        token_queue = {token_queue, tk};
    endfunction

    // works out every result one accepted token causes and updates the stack
    function automatic void balance_step(bbc_pkg::token_t tk);
        logic [bbc_pkg::KIND_W-1:0] kind;
        bbc_pkg::status_t           st;
        logic [bbc_pkg::LINE_W-1:0] pl;
        logic [bbc_pkg::COL_W-1:0]  pc;
        kind = tk.kind;
        st   = bbc_pkg::ST_OK;
        pl   = '0;
        pc   = '0;
        // a bracket of an unknown pair counts as an ordinary token
        if (int'(tk.btype) >= bbc_pkg::BRACKET_TYPES)
            kind = bbc_pkg::KIND_OTHER;
        if (list_broken)
        begin
            st = bbc_pkg::ST_IGNORED;
        end
        else if (kind == bbc_pkg::KIND_OPEN)
        begin
            if (open_depth >= bbc_pkg::STACK_DEPTH)
            begin
                st = bbc_pkg::ST_OVERFLOW;
            end
            else
            begin
                open_type[open_depth] = tk.btype;
                open_line[open_depth] = tk.line;
                open_col[open_depth]  = tk.col;
                open_depth++;
            end
        end
        else if (kind == bbc_pkg::KIND_CLOSE)
        begin
            if (open_depth == 0)
            begin
                st = bbc_pkg::ST_NO_OPENER;
                list_broken = 1'b1;
            end
            else if (open_type[open_depth-1] != tk.btype)
            begin
                st = bbc_pkg::ST_MISMATCH;
                pl = open_line[open_depth-1];
                pc = open_col[open_depth-1];
                list_broken = 1'b1;
            end
            else
            begin
                open_depth--;
            end
        end

        if (!tk.last)
        begin
            add_result(st, pl, pc, open_depth, list_broken, 1'b0);
        end
        else
        begin
            if (list_broken || open_depth == 0)
            begin
                add_result(st, pl, pc, open_depth, list_broken, 1'b1);
            end
            else
            begin
                // own result first, then every unclosed opener from the bottom
                add_result(st, pl, pc, open_depth, 1'b0, 1'b0);
                for (int i = 0; i < open_depth; i++)
                    add_result(bbc_pkg::ST_UNCLOSED, open_line[i], open_col[i],
                               open_depth, 1'b0, i == open_depth - 1);
            end
            open_depth  = 0;
            list_broken = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // gap length: mostly short, now and then long
    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic bbc_pkg::token_t make_token(logic [bbc_pkg::KIND_W-1:0] kind,
                                                   logic [bbc_pkg::TYPE_W-1:0] bt,
                                                   logic [bbc_pkg::LINE_W-1:0] ln,
                                                   logic [bbc_pkg::COL_W-1:0] cl,
                                                   logic fin);
        bbc_pkg::token_t tk;
        tk.kind  = kind;
        tk.btype = bt;
        tk.line  = ln;
        tk.col   = cl;
        tk.last  = fin;
        return tk;
    endfunction

    function automatic bbc_pkg::token_t rand_token(logic [bbc_pkg::KIND_W-1:0] kind,
                                                   logic [bbc_pkg::TYPE_W-1:0] bt,
                                                   logic fin);
        return make_token(kind, bt, bbc_pkg::LINE_W'($urandom_range(0, 65535)),
                          bbc_pkg::COL_W'($urandom_range(0, 4095)), fin);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued tokens on s_, predicts on every transaction
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : token_driver
        bbc_pkg::token_t                tk;
        logic [bbc_pkg::IN_TDATA_W-1:0] td;
        logic [bbc_pkg::IN_TUSER_W-1:0] tu;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                balance_step(cur_token);
                tokens_taken <= tokens_taken + 1;
            end
            // stretches with no idling at all come and go
            if ($urandom_range(0, 79) == 0)
                tx_steady = !tx_steady;
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || token_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    tk = token_queue.pop_front();
                    td = '0;
                    td[bbc_pkg::LINE_LSB +: bbc_pkg::LINE_W] = tk.line;
                    td[bbc_pkg::COL_LSB  +: bbc_pkg::COL_W]  = tk.col;
                    tu = '0;
                    tu[bbc_pkg::KIND_LSB +: bbc_pkg::KIND_W] = tk.kind;
                    tu[bbc_pkg::TYPE_LSB +: bbc_pkg::TYPE_W] = tk.btype;
                    cur_token <= tk;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= td;
                    s_tuser   <= tu;
                    s_tlast   <= tk.last;
                    gap_left  <= (tx_steady || $urandom_range(0, 1)) ? 0 : idle_len();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: paces m_tready and checks each result transaction
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        bbc_pkg::result_t want;
        logic             next_ready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with none expected: status %0d, open_count %0d",
                           m_tuser,
                           m_tdata[bbc_pkg::OUT_COUNT_LSB +: bbc_pkg::COUNT_W]);
                    error_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("partner_line", want.partner_line,
                                m_tdata[bbc_pkg::OUT_LINE_LSB +: bbc_pkg::LINE_W]);
                    check_field("partner_column", want.partner_column,
                                m_tdata[bbc_pkg::OUT_COL_LSB +: bbc_pkg::COL_W]);
                    check_field("open_count", want.open_count,
                                m_tdata[bbc_pkg::OUT_COUNT_LSB +: bbc_pkg::COUNT_W]);
                    check_field("list_failed", want.list_failed,
                                m_tdata[bbc_pkg::OUT_FAILED_LSB]);
                    check_field("last_result", want.last, m_tlast);
                end
            end

            if ($urandom_range(0, 79) == 0)
                rx_steady = !rx_steady;

            // one long hold mid-run so the block backs up and drops s_tready
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (!held_off && tokens_taken >= HOLD_AFTER)
            begin
                held_off   = 1'b1;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
            m_tready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("bracket_balance_checker_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed lists, then random lists, then drain and verdict
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        bbc_pkg::token_t            lst[$];
        logic [bbc_pkg::TYPE_W-1:0] gen_stack[$];
        logic [bbc_pkg::KIND_W-1:0] k;
        logic [bbc_pkg::TYPE_W-1:0] t;
        int                         made;
        int                         len;
        int                         pick;
        int                         extra;
        bit                         deep_done;
        bit                         closing;

        // nested pairs of every type at the extremes of line and column,
        // spare kind, balanced finish
        queue_token(make_token(bbc_pkg::KIND_OPEN,  BR_ROUND,  '0, '0, 1'b0));
        queue_token(make_token(bbc_pkg::KIND_OPEN,  BR_SQUARE, '1, '1, 1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_CURLY,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_ANGLE,  1'b0));
        queue_token(make_token(bbc_pkg::KIND_CLOSE, BR_ANGLE,  '1, '0, 1'b0));
        queue_token(make_token(bbc_pkg::KIND_CLOSE, BR_CURLY,  '0, '1, 1'b0));
        queue_token(rand_token(bbc_pkg::KIND_CLOSE, BR_SQUARE, 1'b0));
        queue_token(rand_token(bbc_pkg::KIND_CLOSE, BR_ROUND,  1'b0));
        queue_token(rand_token(KIND_SPARE,          BR_CURLY,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OTHER, BR_ANGLE,  1'b1));
        // closer on an empty stack, then ignored tokens up to the last one
        queue_token(rand_token(bbc_pkg::KIND_CLOSE, BR_SQUARE, 1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_ROUND,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OTHER, BR_ROUND,  1'b1));
        // type mismatch reports the opener on top, last token ignored
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_ROUND,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_SQUARE, 1'b0));
        queue_token(rand_token(bbc_pkg::KIND_CLOSE, BR_ROUND,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_CLOSE, BR_SQUARE, 1'b1));
        // openers left at the end, the last token itself an opener
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_CURLY,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_ANGLE,  1'b0));
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_SQUARE, 1'b1));
        // the last token causes the error itself
        queue_token(rand_token(bbc_pkg::KIND_OPEN,  BR_SQUARE, 1'b0));
        queue_token(rand_token(bbc_pkg::KIND_CLOSE, BR_CURLY,  1'b1));

        // random lists: mostly well formed with random content, some noise
        made      = 0;
        deep_done = 1'b0;
        while (made < RANDOM_TOKENS)
        begin
            if ((!deep_done && made > 100) || $urandom_range(0, 49) == 0)
            begin
                // fill the stack past its depth, then a full unclosed report
                extra = $urandom_range(1, 3);
                for (int i = 0; i < bbc_pkg::STACK_DEPTH + extra; i++)
                    queue_token(rand_token(bbc_pkg::KIND_OPEN,
                                           bbc_pkg::TYPE_W'($urandom_range(0, 3)), 1'b0));
                queue_token(rand_token(bbc_pkg::KIND_OTHER,
                                       bbc_pkg::TYPE_W'($urandom_range(0, 3)), 1'b1));
                made += bbc_pkg::STACK_DEPTH + extra + 1;
                deep_done = 1'b1;
            end
            else
            begin
                lst.delete();
                gen_stack.delete();
                len     = $urandom_range(1, 24);
                closing = $urandom_range(0, 1);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 99);
                    t    = bbc_pkg::TYPE_W'($urandom_range(0, 3));
                    if (pick < 40 || (pick < 72 && gen_stack.size() == 0))
                    begin
                        k = bbc_pkg::KIND_OPEN;
                        gen_stack = {gen_stack, t};
                    end
                    else if (pick < 72)
                    begin
                        k = bbc_pkg::KIND_CLOSE;
                        t = gen_stack[$];
                        gen_stack.delete(gen_stack.size() - 1);
                    end
                    else if (pick < 88)
                    begin
                        k = (pick < 84) ? bbc_pkg::KIND_OTHER : KIND_SPARE;
                    end
                    else
                    begin
                        // noise: any kind and type, may break the list
                        k = bbc_pkg::KIND_W'($urandom_range(0, 3));
                        if (k == bbc_pkg::KIND_OPEN)
                            gen_stack = {gen_stack, t};
                        else if (k == bbc_pkg::KIND_CLOSE && gen_stack.size() != 0 &&
                                 gen_stack[$] == t)
                            gen_stack.delete(gen_stack.size() - 1);
                    end
                    lst = {lst, rand_token(k, t, 1'b0)};
                end
                // close whatever is still open, or leave it for the report
                if (closing)
                begin
                    while (gen_stack.size() != 0)
                    begin
                        t = gen_stack[$];
                        gen_stack.delete(gen_stack.size() - 1);
                        lst = {lst, rand_token(bbc_pkg::KIND_CLOSE, t, 1'b0)};
                    end
                end
                lst[$].last = 1'b1;
                foreach (lst[i])
                    queue_token(lst[i]);
                made += lst.size();
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // all tokens taken, then all results in, then a quiet tail
        while (token_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && due_results.size() == 0)
            $display("bracket_balance_checker_tb: done, clean");
        else
            $display("bracket_balance_checker_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/bbc_pkg.sv
design/bbc_stack_mem.sv
design/bbc_ctrl.sv
design/bracket_balance_checker.sv
test/bracket_balance_checker_tb.sv
